// ===== hw/rtl/mau_pkg.sv =====
// ----------------------------------------------------------------------------
// mau_pkg: shared types and constants of the modular arithmetic unit
// Holds command codes, residue width and the remainder step function.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int ResBits = 31;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_INV = 2'd3
  } cmd_e;

  // one bit of restoring remainder: shift in a bit, subtract m if it fits
  function automatic logic [ResBits-1:0] rem_step(input logic [ResBits-1:0] r,
                                                  input logic b,
                                                  input logic [ResBits-1:0] m);
    logic [ResBits:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[ResBits-1:0];
  endfunction

endpackage

// ===== hw/rtl/mau_ifs.sv =====
// ----------------------------------------------------------------------------
// mau_ifs: valid/ready channels of the modular arithmetic unit
// Input channel carries cmd and operands, output channel the residue.
// ----------------------------------------------------------------------------
interface mau_in_if #(parameter int OperandBits = 32);
  logic                   valid;
  logic                   ready;
  logic [1:0]             cmd;
  logic [OperandBits-1:0] operand_a;
  logic [OperandBits-1:0] operand_b;
  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface mau_out_if;
  logic                        valid;
  logic                        ready;
  logic [mau_pkg::ResBits-1:0] residue;
  logic                        bad_command;
  modport source (output valid, residue, bad_command, input ready);
  modport sink   (input valid, residue, bad_command, output ready);
endinterface

// ===== hw/rtl/mau_front.sv =====
// ----------------------------------------------------------------------------
// mau_front: operand decode and exact arithmetic
// Forms the signed sum, difference or product and splits it into magnitude
// and sign, registered, for the reduction pipeline.
// ----------------------------------------------------------------------------
module mau_front #(
  parameter int OperandBits = 32,
  parameter int MagBits     = 2 * OperandBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mau_in_if.sink             in_i,
  output logic               push_o,
  input  logic               push_ready_i,
  output logic [MagBits+1:0] push_data_o
);

  logic                      v_q, v_d;
  logic [MagBits-1:0]        mag_q, mag_d;
  logic                      neg_q, neg_d;
  logic                      bad_q, bad_d;
  logic signed [MagBits-1:0] a_s, b_s, x;
  logic signed [MagBits-1:0] prod;

  assign in_i.ready = !v_q || push_ready_i;

  always_comb begin
    a_s = MagBits'(signed'(in_i.operand_a));
    b_s = MagBits'(signed'(in_i.operand_b));
    prod = signed'(in_i.operand_a) * signed'(in_i.operand_b);
    bad_d = 1'b0;
    case (mau_pkg::cmd_e'(in_i.cmd))
      mau_pkg::CMD_ADD: x = a_s + b_s;
      mau_pkg::CMD_SUB: x = a_s - b_s;
      mau_pkg::CMD_MUL: x = prod;
      default: begin
        x = '0;
        bad_d = 1'b1;
      end
    endcase
    neg_d = x[MagBits-1];
    mag_d = neg_d ? MagBits'(-x) : MagBits'(x);
    v_d   = in_i.ready ? in_i.valid : v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      bad_q <= bad_d;
    end
  end

  assign push_o      = v_q;
  assign push_data_o = {bad_q, neg_q, mag_q};

endmodule

// ===== hw/rtl/mau_fifo.sv =====
// ----------------------------------------------------------------------------
// mau_fifo: two-entry queue between front and back
// Lets the front keep accepting while the reduction pipeline is stalled.
// ----------------------------------------------------------------------------
module mau_fifo #(
  parameter int Width = 66
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/mau_back.sv =====
// ----------------------------------------------------------------------------
// mau_back: pipelined reduction modulo m
// One remainder bit per stage over the magnitude, then a combinational sign
// fix behind the last stage register.
// ----------------------------------------------------------------------------
module mau_back #(
  parameter int MagBits = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mau_pkg::ResBits-1:0] modulus_i,
  input  logic                        pop_valid_i,
  output logic                        pop_o,
  input  logic [MagBits+1:0]          pop_data_i,
  mau_out_if.source                   out_o
);

  localparam int R = mau_pkg::ResBits;

  logic         v_q   [MagBits];
  logic [R-1:0] r_q   [MagBits];
  logic [MagBits-1:0] mag_q [MagBits];
  logic         neg_q [MagBits];
  logic         bad_q [MagBits];
  logic         adv;
  logic [R-1:0] last_r;

  // whole pipeline moves unless the result at its tail is stalled
  assign adv   = !v_q[MagBits-1] || out_o.ready;
  assign pop_o = adv;

  for (genvar k = 0; k < MagBits; k++) begin : g_stage
    logic               v_in, neg_in, bad_in;
    logic [R-1:0]       r_in;
    logic [MagBits-1:0] mag_in;
    if (k == 0) begin : g_first
      assign v_in   = pop_valid_i;
      assign r_in   = '0;
      assign mag_in = pop_data_i[MagBits-1:0];
      assign neg_in = pop_data_i[MagBits];
      assign bad_in = pop_data_i[MagBits+1];
    end else begin : g_rest
      assign v_in   = v_q[k-1];
      assign r_in   = r_q[k-1];
      assign mag_in = mag_q[k-1];
      assign neg_in = neg_q[k-1];
      assign bad_in = bad_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        r_q[k]   <= mau_pkg::rem_step(r_in, mag_in[MagBits-1], modulus_i);
        mag_q[k] <= {mag_in[MagBits-2:0], 1'b0};
        neg_q[k] <= neg_in;
        bad_q[k] <= bad_in;
      end
    end
  end

  assign last_r = r_q[MagBits-1];

  always_comb begin
    out_o.valid       = v_q[MagBits-1];
    out_o.bad_command = bad_q[MagBits-1];
    if (modulus_i == '0) begin
      out_o.residue = '0;
    end else if (neg_q[MagBits-1] && last_r != '0) begin
      out_o.residue = modulus_i - last_r;
    end else begin
      out_o.residue = last_r;
    end
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid)
    else $error("result dropped while stalled");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_command |-> out_o.residue == '0)
    else $error("bad command gives nonzero residue");
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && modulus_i != '0 |-> out_o.residue < modulus_i)
    else $error("residue not below modulus");

endmodule

// ===== hw/rtl/modular_add_sub_mul_unit_top.sv =====
// ----------------------------------------------------------------------------
// modular_add_sub_mul_unit_top: modular add, subtract and multiply
// Reduces the exact result of two signed operands into 0 to m-1.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries cmd, operand_a and operand_b; out_o carries residue and
//   bad_command, both valid/ready. cfg_we_i with cfg_wdata_i sets the modulus;
//   the user must write it only while no item is in flight, as the block
//   itself does not enforce this. Throughput: one item per cycle while the
//   receiver does not stall. The front forms the exact sum, difference or
//   product in a register stage, a two-entry queue follows, then the
//   reduction pipeline takes one remainder bit per stage, 2*OPERAND_BITS
//   stages.
//   cmd 3 gives bad_command 1 and residue 0; a zero modulus gives residue 0.
//   Reset empties all stages and the queue and sets the modulus to 2.
//   When the receiver stalls, the reduction pipeline holds as a whole, the
//   queue fills, and in_i.ready drops once queue and front stage are full.
// ----------------------------------------------------------------------------
module modular_add_sub_mul_unit_top #(
  parameter int OPERAND_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mau_pkg::ResBits-1:0] cfg_wdata_i,
  mau_in_if.sink                      in_i,
  mau_out_if.source                   out_o
);

  localparam int MagBits = 2 * OPERAND_BITS;

  logic [mau_pkg::ResBits-1:0] modulus_q;
  logic                        push, push_ready, pop_valid, pop;
  logic [MagBits+1:0]          push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= mau_pkg::ResBits'(2);
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  mau_front #(.OperandBits(OPERAND_BITS), .MagBits(MagBits)) u_front (
    .clk_i, .rst_ni, .in_i,
    .push_o(push), .push_ready_i(push_ready), .push_data_o(push_data)
  );

  mau_fifo #(.Width(MagBits + 2)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .push_ready_o(push_ready), .push_data_i(push_data),
    .pop_valid_o(pop_valid), .pop_i(pop), .pop_data_o(pop_data)
  );

  mau_back #(.MagBits(MagBits)) u_back (
    .clk_i, .rst_ni, .modulus_i(modulus_q),
    .pop_valid_i(pop_valid), .pop_o(pop), .pop_data_i(pop_data), .out_o
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the modular arithmetic unit
// Drives add, subtract, multiply and unsupported commands through the valid/
// ready channels over several moduli, and compares each residue and error
// flag against an internal predictor, under random bursts and output stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int OpBits  = 32;
  localparam int Latency = 2 * OpBits + 2;
  localparam int MaxCycles = 400000;

  typedef struct packed {
    logic [mau_pkg::ResBits-1:0] residue;
    logic                        bad_command;
  } residue_t;

  typedef struct {
    mau_pkg::cmd_e      cmd;
    logic [OpBits-1:0]  a;
    logic [OpBits-1:0]  b;
    logic               known;
    residue_t           res;
  } op_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [mau_pkg::ResBits-1:0] cfg_wdata_i = '0;

  mau_in_if #(.OperandBits(OpBits)) in_ch ();
  mau_out_if out_ch ();

  modular_add_sub_mul_unit_top #(.OPERAND_BITS(OpBits)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [mau_pkg::ResBits-1:0] modulus_q;
  residue_t                    expected_q[$];
  int                          errors = 0;
  int                          cycles = 0;
  bit                          long_hold = 1'b0;

  function automatic residue_t predict_residue(mau_pkg::cmd_e cmd, logic [OpBits-1:0] a,
                                               logic [OpBits-1:0] b,
                                               logic [mau_pkg::ResBits-1:0] m);
    residue_t        r;
    longint signed   x;
    longint signed   sa;
    longint signed   sb;
    longint signed   mm;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    mm = longint'({33'd0, m});
    r.bad_command = (cmd == mau_pkg::CMD_INV);
    case (cmd)
      mau_pkg::CMD_ADD: x = sa + sb;
      mau_pkg::CMD_SUB: x = sa - sb;
      mau_pkg::CMD_MUL: x = sa * sb;
      default: x = 0;
    endcase
    if (cmd == mau_pkg::CMD_INV || m == 0) begin
      r.residue = '0;
    end else begin
      x = x % mm;
      if (x < 0) x = x + mm;
      r.residue = x[mau_pkg::ResBits-1:0];
    end
    return r;
  endfunction

  // inputs move on the falling edge
  task automatic send_op(mau_pkg::cmd_e cmd, logic [OpBits-1:0] a, logic [OpBits-1:0] b);
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_q.push_back(predict_residue(cmd, a, b, modulus_q));
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain_and_set_modulus(logic [mau_pkg::ResBits-1:0] m);
    go_idle();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    modulus_q = m;
  endtask

  function automatic logic [OpBits-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // receiver: own stall pattern, plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (Latency * 3) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (cycles % 500 < 150) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    residue_t exp_r;
    cycles <= cycles + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected item: residue %0d bad_command %0b",
               out_ch.residue, out_ch.bad_command);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_ch.residue !== exp_r.residue) begin
          $error("residue: expected %0d actual %0d", exp_r.residue, out_ch.residue);
          errors++;
        end
        if (out_ch.bad_command !== exp_r.bad_command) begin
          $error("bad_command: expected %0b actual %0b",
                 exp_r.bad_command, out_ch.bad_command);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (cycles >= MaxCycles);
    $display("tb_top NOT OK");
    $finish;
  end

  op_row_t op_table[$];
  logic [mau_pkg::ResBits-1:0] moduli[$];

  function automatic op_row_t row(mau_pkg::cmd_e c, logic [OpBits-1:0] a,
                                  logic [OpBits-1:0] b, logic k,
                                  logic [mau_pkg::ResBits-1:0] r, logic bad);
    op_row_t o;
    o.cmd = c; o.a = a; o.b = b; o.known = k;
    o.res.residue = r; o.res.bad_command = bad;
    return o;
  endfunction

  initial begin
    residue_t p;
    int burst;
    int gap;
    in_ch.valid = 1'b0;
    in_ch.cmd = mau_pkg::CMD_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    modulus_q = 31'd2;
    // directed rows run with the reset modulus of 2
    op_table.push_back(row(mau_pkg::CMD_ADD, 32'd3, 32'd4, 1'b1, 31'd1, 1'b0));
    op_table.push_back(row(mau_pkg::CMD_SUB, 32'd0, 32'd1, 1'b1, 31'd1, 1'b0));
    op_table.push_back(row(mau_pkg::CMD_MUL, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 31'd1, 1'b0));
    op_table.push_back(row(mau_pkg::CMD_INV, 32'd5, 32'd7, 1'b1, 31'd0, 1'b1));
    op_table.push_back(row(mau_pkg::CMD_INV, 32'hffff_ffff, 32'h8000_0000, 1'b1, 31'd0, 1'b1));
    op_table.push_back(row(mau_pkg::CMD_ADD, 32'h8000_0000, 32'h8000_0000, 1'b0, 31'd0, 1'b0));
    op_table.push_back(row(mau_pkg::CMD_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 31'd0, 1'b0));
    op_table.push_back(row(mau_pkg::CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 31'd0, 1'b0));
    op_table.push_back(row(mau_pkg::CMD_SUB, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 31'd0, 1'b0));
    op_table.push_back(row(mau_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0, 31'd0, 1'b0));
    op_table.push_back(row(mau_pkg::CMD_MUL, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 31'd0, 1'b0));
    op_table.push_back(row(mau_pkg::CMD_MUL, 32'hffff_fffe, 32'd3, 1'b0, 31'd0, 1'b0));
    op_table.push_back(row(mau_pkg::CMD_SUB, 32'hffff_fff6, 32'd0, 1'b0, 31'd0, 1'b0));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (op_table[i]) begin
      send_op(op_table[i].cmd, op_table[i].a, op_table[i].b);
      if (op_table[i].known) begin
        p = expected_q[$];
        if (p !== op_table[i].res) begin
          $error("predictor row %0d: expected %h got %h", i, op_table[i].res, p);
          errors++;
        end
      end
    end

    // extremes first, then ordinary and random moduli
    moduli = '{31'd1, 31'h7fff_ffff, 31'd0, 31'd7, 31'd12345, 31'h4000_0000, 31'd2};
    for (int ph = 0; ph < moduli.size() + 3; ph++) begin
      drain_and_set_modulus(ph < moduli.size() ? moduli[ph] : 31'($urandom));
      // exact negative multiples of m: -m and -3*m
      if (modulus_q != 0) begin
        send_op(mau_pkg::CMD_SUB, 32'd0, {1'b0, modulus_q});
        send_op(mau_pkg::CMD_MUL, -32'sd3, {1'b0, modulus_q});
      end
      if (ph == 3) long_hold = 1'b1;
      for (int n = 0; n < 40; ) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && n < 40; k++, n++) begin
          send_op(mau_pkg::cmd_e'($urandom_range(0, 3)), rand_operand(), rand_operand());
        end
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
          go_idle();
          repeat (gap) @(negedge clk_i);
        end
      end
    end

    go_idle();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mau_pkg.sv
hw/rtl/mau_ifs.sv
hw/rtl/mau_front.sv
hw/rtl/mau_fifo.sv
hw/rtl/mau_back.sv
hw/rtl/modular_add_sub_mul_unit_top.sv
tb/sv/tb_top.sv
